>>> hdl/afcs_pkg.sv
// ----------------------------------------------------------------------------
// afcs_pkg
// shared types and constants of the fade overlay sequencer
// ----------------------------------------------------------------------------
package afcs_pkg;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned FRAME_W = LEN_W + 1;
  localparam int unsigned NUM_W   = 25;
  localparam int unsigned DEN_W   = LEN_W + 1;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned COMP_W  = 8;
  localparam int unsigned KIND_W  = 3;

  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FADE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CROSS = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET = 3'd4;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> hdl/afcs_in_if.sv
// ----------------------------------------------------------------------------
// afcs_in_if
// request channel of the fade overlay sequencer
// ----------------------------------------------------------------------------
interface afcs_in_if;

  logic                         valid;
  logic                         ready;
  logic [afcs_pkg::KIND_W-1:0]  kind;
  logic                         direction_in;
  logic [afcs_pkg::LEN_W-1:0]   first_length;
  logic [afcs_pkg::LEN_W-1:0]   hold_frames;
  logic [afcs_pkg::LEN_W-1:0]   second_length;
  logic [afcs_pkg::COMP_W-1:0]  red_in;
  logic [afcs_pkg::COMP_W-1:0]  green_in;
  logic [afcs_pkg::COMP_W-1:0]  blue_in;

  modport source (
    output valid, kind, direction_in, first_length, hold_frames, second_length,
           red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, kind, direction_in, first_length, hold_frames, second_length,
           red_in, green_in, blue_in,
    output ready
  );

endinterface

>>> hdl/afcs_out_if.sv
// ----------------------------------------------------------------------------
// afcs_out_if
// status channel of the fade overlay sequencer
// ----------------------------------------------------------------------------
interface afcs_out_if;

  logic                          valid;
  logic                          ready;
  logic [afcs_pkg::ALPHA_W-1:0]  alpha;
  logic                          busy_res;
  logic                          fully_out;
  logic                          visible;
  logic [afcs_pkg::COMP_W-1:0]   red_out;
  logic [afcs_pkg::COMP_W-1:0]   green_out;
  logic [afcs_pkg::COMP_W-1:0]   blue_out;

  modport source (
    output valid, alpha, busy_res, fully_out, visible, red_out, green_out, blue_out,
    input  ready
  );

  modport sink (
    input  valid, alpha, busy_res, fully_out, visible, red_out, green_out, blue_out,
    output ready
  );

endinterface

>>> hdl/alpha_fade_crossfade_sequencer_core.sv
// ----------------------------------------------------------------------------
// alpha_fade_crossfade_sequencer_core
// fade overlay controller with crossfade sequencing
// ----------------------------------------------------------------------------
// Each request gives one status item. A tick that moves a running fade
// goes from acceptance to the status item in these steps: accept the
// request, form the numerator 510*n+L (less one in a fade in), eight steps
// of the restoring divider (one quotient bit a cycle), finish, and load the
// output register once any earlier status has been taken. Every other request
// goes from acceptance straight to that load. The block takes one request at a
// time and is ready again once the status sits in the output register, even while that status still waits to be taken.
module alpha_fade_crossfade_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  afcs_in_if.sink     in_ch,
  afcs_out_if.source  out_ch
);

  localparam int unsigned LW = afcs_pkg::LEN_W;
  localparam int unsigned FW = afcs_pkg::FRAME_W;
  localparam int unsigned NW = afcs_pkg::NUM_W;
  localparam int unsigned AW = afcs_pkg::ALPHA_W;
  localparam int unsigned CW = afcs_pkg::COMP_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;

  logic           fin_r, fout_r, cross_r;
  logic [FW-1:0]  frame_r;
  logic [LW-1:0]  phase_r, pause_r, in_len_r;
  logic [AW-1:0]  alpha_r;
  logic [CW-1:0]  red_r, green_r, blue_r;

  logic           out_valid_r;
  logic [AW-1:0]  out_alpha_r;
  logic           out_busy_r, out_full_r, out_vis_r;
  logic [CW-1:0]  out_red_r, out_green_r, out_blue_r;

  logic           accept;
  logic [FW-1:0]  frame_inc;
  logic           past_end;
  logic [FW-1:0]  hold_end;
  logic           cross_to_in;
  logic [LW-1:0]  first_len, second_len;
  logic [LW-1:0]  len_eff;
  logic [FW-1:0]  n_eff;
  logic [NW:0]    numer;
  logic           out_load;

  afcs_pkg::div_req_t div_req;
  afcs_pkg::div_rsp_t div_rsp;

  afcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign frame_inc  = (frame_r == {FW{1'b1}}) ? frame_r : frame_r + 1'b1;
  assign past_end   = (frame_inc > {1'b0, phase_r}) && (phase_r != '0);
  assign hold_end   = {1'b0, phase_r} + {1'b0, pause_r};
  assign cross_to_in = past_end && cross_r && fout_r && (frame_inc > hold_end);
  assign first_len  = (in_ch.first_length == '0) ? LW'(1) : in_ch.first_length;
  assign second_len = (in_ch.second_length == '0) ? LW'(1) : in_ch.second_length;

  // numerator of the rounded alpha division
  assign len_eff = (phase_r == '0) ? LW'(1) : phase_r;
  assign n_eff   = (frame_r > {1'b0, len_eff}) ? {1'b0, len_eff} : frame_r;
  assign numer   = ({n_eff, 9'b0} - {8'b0, n_eff, 1'b0})
                 + (NW+1)'(len_eff) - (NW+1)'(fin_r);

  assign div_req.start = (state_r == ST_PREP);
  assign div_req.num   = numer[NW-1:0];
  assign div_req.den   = {len_eff, 1'b0};

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.kind == afcs_pkg::KIND_TICK && (fin_r || fout_r) && !past_end) begin
            state_nxt = ST_PREP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PREP: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fin_r    <= 1'b0;
      fout_r   <= 1'b0;
      cross_r  <= 1'b0;
      frame_r  <= '0;
      phase_r  <= '0;
      pause_r  <= '0;
      in_len_r <= '0;
      alpha_r  <= '0;
      red_r    <= '0;
      green_r  <= '0;
      blue_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        case (in_ch.kind)
          afcs_pkg::KIND_TICK: begin
            if (fin_r || fout_r) begin
              frame_r <= cross_to_in ? '0 : frame_inc;
              if (past_end) begin
                if (cross_r) begin
                  if (cross_to_in) begin
                    phase_r <= in_len_r;
                    fin_r   <= 1'b1;
                    fout_r  <= 1'b0;
                  end else if (fin_r) begin
                    cross_r <= 1'b0;
                    fin_r   <= 1'b0;
                  end
                end else begin
                  fin_r  <= 1'b0;
                  fout_r <= 1'b0;
                end
              end
            end
          end
          afcs_pkg::KIND_FADE: begin
            phase_r <= first_len;
            fin_r   <= in_ch.direction_in;
            fout_r  <= !in_ch.direction_in;
            frame_r <= '0;
            red_r   <= in_ch.red_in;
            green_r <= in_ch.green_in;
            blue_r  <= in_ch.blue_in;
          end
          afcs_pkg::KIND_CROSS: begin
            pause_r  <= in_ch.hold_frames;
            in_len_r <= second_len;
            cross_r  <= 1'b1;
            phase_r  <= first_len;
            fin_r    <= 1'b0;
            fout_r   <= 1'b1;
            frame_r  <= '0;
            red_r    <= in_ch.red_in;
            green_r  <= in_ch.green_in;
            blue_r   <= in_ch.blue_in;
          end
          afcs_pkg::KIND_CLEAR: begin
            fin_r   <= 1'b0;
            fout_r  <= 1'b0;
            alpha_r <= '0;
            phase_r <= '0;
          end
          afcs_pkg::KIND_RESET: begin
            phase_r <= '0;
            cross_r <= 1'b0;
            alpha_r <= '0;
            fin_r   <= 1'b0;
            fout_r  <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_r == ST_WAIT && div_rsp.done) begin
        alpha_r <= fin_r ? afcs_pkg::ALPHA_FULL - div_rsp.quot : div_rsp.quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_alpha_r <= alpha_r;
      out_busy_r  <= fin_r || fout_r;
      out_full_r  <= (alpha_r == afcs_pkg::ALPHA_FULL);
      out_vis_r   <= (alpha_r != '0) && (phase_r != '0);
      out_red_r   <= red_r;
      out_green_r <= green_r;
      out_blue_r  <= blue_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.alpha     = out_alpha_r;
  assign out_ch.busy_res  = out_busy_r;
  assign out_ch.fully_out = out_full_r;
  assign out_ch.visible   = out_vis_r;
  assign out_ch.red_out   = out_red_r;
  assign out_ch.green_out = out_green_r;
  assign out_ch.blue_out  = out_blue_r;

endmodule

>>> hdl/afcs_div.sv
// ----------------------------------------------------------------------------
// afcs_div
// restoring divider, one quotient bit per cycle, quotient below 256
// ----------------------------------------------------------------------------
module afcs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  afcs_pkg::div_req_t req,
  output afcs_pkg::div_rsp_t rsp
);

  localparam int unsigned QW = afcs_pkg::ALPHA_W;
  localparam int unsigned DW = afcs_pkg::DEN_W;
  localparam int unsigned NW = afcs_pkg::NUM_W;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  logic [DW-1:0]          rem_r;
  logic [QW-1:0]          low_r;
  logic [QW-1:0]          quot_r;
  logic [DW-1:0]          den_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;
  logic                   done_r;

  logic [DW:0]            trial;
  logic                   fits;
  logic [DW:0]            diff;

  assign trial = {rem_r, low_r[QW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == CNT_LAST);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num[NW-1:QW];
      low_r  <= req.num[QW-1:0];
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DW-1:0] : trial[DW-1:0];
      low_r  <= {low_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

>>> hdl/afcs_chk.sv
// ----------------------------------------------------------------------------
// afcs_chk
// port-level checks of the fade overlay sequencer
// ----------------------------------------------------------------------------
module afcs_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [afcs_pkg::ALPHA_W-1:0]  alpha,
  input  logic                          fully_out,
  input  logic                          visible
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("status valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(alpha))
    else $error("stalled status changed");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fully_out == (alpha == afcs_pkg::ALPHA_FULL))
    else $error("fully_out disagrees with alpha");

  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && visible |-> alpha != '0)
    else $error("visible with zero alpha");

endmodule

bind alpha_fade_crossfade_sequencer_core afcs_chk u_afcs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .alpha     (out_ch.alpha),
  .fully_out (out_ch.fully_out),
  .visible   (out_ch.visible)
);
